// File: src/sir_pkg.sv
// Shared types and constants for the serial id registry.
`default_nettype none
package sir_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int HANDLE_W    = 32;
	localparam int ID_W        = $clog2(TABLE_DEPTH);
	localparam int HINT_W      = ID_W + 1;

	typedef enum logic [3:0] {
		OP_ASSIGN     = 4'd0,
		OP_UNASSIGN   = 4'd1,
		OP_GET        = 4'd2,
		OP_FIRST      = 4'd3,
		OP_LAST       = 4'd4,
		OP_NEXT       = 4'd5,
		OP_PREV       = 4'd6,
		OP_FIRST_FREE = 4'd7,
		OP_COUNT      = 4'd8,
		OP_COMPACT    = 4'd9,
		OP_CLEAR      = 4'd10
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NONE     = 3'd1,
		ST_FULL     = 3'd2,
		ST_OCCUPIED = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	typedef struct packed {
		logic [3:0]          opcode;
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] handle;
	} request_t;

	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     result_id;
		logic [HANDLE_W-1:0] result_handle;
		logic [ID_W-1:0]     old_id;
		logic [ID_W-1:0]     occupied_count;
		logic                last;
	} result_t;

	// search command for the shared scan unit: bounds are inclusive
	typedef struct packed {
		logic              invert;
		logic              from_top;
		logic [HINT_W-1:0] lo;
		logic [ID_W-1:0]   hi;
	} scan_cmd_t;

	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] idx;
	} scan_rsp_t;

endpackage
`default_nettype wire

// File: src/sir_scan.sv
// Shared scan unit: priority search for a set bit (or a clear bit when inverted) of the occupancy map within bounds.
`default_nettype none
module sir_scan import sir_pkg::*; (
	input  wire logic [TABLE_DEPTH-1:0] map,
	input  wire scan_cmd_t              cmd,
	output scan_rsp_t                   rsp
);

	logic [TABLE_DEPTH-1:0] masked;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			masked[i] = (map[i] ^ cmd.invert) && (HINT_W'(i) >= cmd.lo) &&
				(ID_W'(i) <= cmd.hi);
		end
	end

	always_comb begin
		rsp.hit = |masked;
		rsp.idx = '0;
		if (cmd.from_top) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (masked[i]) begin
					rsp.idx = ID_W'(i);
				end
			end
		end else begin
			for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
				if (masked[i]) begin
					rsp.idx = ID_W'(i);
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: src/serial_id_registry.sv
// Serial id registry top level: sequencer, occupancy state and handle memory.
`default_nettype none
// A request is taken when start is high and busy is low; busy then stays high
// until the request's last result has been issued. Results come one per strobe
// cycle and cannot be held off. Count, clear, first-free, assign to a free id and
// requests that end in an error are answered from the execute state; requests that
// return a stored handle (get, first, last, next, previous, unassign, assign to an
// occupied id) pass through a further state because of the registered read of the
// handle memory. Compact scans once per entry already in place and scans then moves
// each moved entry, as one shared scan unit and one memory read port serve every step.
module serial_id_registry import sir_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire request_t request,
	output logic          busy,
	output logic          result_strobe,
	output result_t       result
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_READ  = 6'b000100,
		S_UHI   = 6'b001000,
		S_CSCAN = 6'b010000,
		S_CMOVE = 6'b100000
	} state_t;

	localparam logic [ID_W-1:0] TOP_ID = ID_W'(TABLE_DEPTH - 1);

	state_t                 state_q, state_d;
	request_t               req_q;
	logic [TABLE_DEPTH-1:0] map_q, map_d;
	logic [HINT_W-1:0]      hint_q, hint_d;
	logic [ID_W-1:0]        high_q, high_d;
	logic [ID_W-1:0]        cnt_q, cnt_d;
	logic [HINT_W-1:0]      next_q, next_d;
	logic [ID_W-1:0]        src_q, src_d;
	status_t                pst_q, pst_d;
	logic [ID_W-1:0]        pid_q, pid_d;
	result_t                res_q, emit_res;
	logic                   strobe_q, emit;

	logic [HANDLE_W-1:0]    mem [TABLE_DEPTH];
	logic [HANDLE_W-1:0]    rdata_q, wdata;
	logic [ID_W-1:0]        raddr, waddr;
	logic                   we;

	logic [HINT_W-1:0]      pick;
	scan_cmd_t              scmd;
	scan_rsp_t              srsp;

	sir_scan u_scan (
		.map (map_q),
		.cmd (scmd),
		.rsp (srsp)
	);

	always_comb begin
		state_d  = state_q;
		map_d    = map_q;
		hint_d   = hint_q;
		high_d   = high_q;
		cnt_d    = cnt_q;
		next_d   = next_q;
		src_d    = src_q;
		pst_d    = pst_q;
		pid_d    = pid_q;
		we       = 1'b0;
		waddr    = next_q[ID_W-1:0];
		wdata    = rdata_q;
		raddr    = req_q.id;
		emit     = 1'b0;
		emit_res = '{status: ST_OK, default: '0};
		emit_res.last = 1'b1;
		pick     = '0;
		scmd     = '{invert: 1'b0, from_top: 1'b0, lo: HINT_W'(1), hi: TOP_ID};

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (req_q.opcode)
					OP_ASSIGN: begin
						pick = (req_q.id == '0) ? HINT_W'(high_q) + HINT_W'(1) :
							HINT_W'(req_q.id);
						if (pick[HINT_W-1]) begin
							emit = 1'b1;
							emit_res.status = ST_FULL;
						end else if (map_q[pick[ID_W-1:0]]) begin
							raddr   = pick[ID_W-1:0];
							pst_d   = ST_OCCUPIED;
							pid_d   = pick[ID_W-1:0];
							state_d = S_READ;
						end else begin
							we    = 1'b1;
							waddr = pick[ID_W-1:0];
							wdata = req_q.handle;
							map_d = map_q | (TABLE_DEPTH'(1) << pick[ID_W-1:0]);
							if (pick[ID_W-1:0] > high_q) begin
								high_d = pick[ID_W-1:0];
							end
							cnt_d = cnt_q + ID_W'(1);
							emit  = 1'b1;
							emit_res.result_id     = pick[ID_W-1:0];
							emit_res.result_handle = req_q.handle;
						end
					end
					OP_UNASSIGN: begin
						if (req_q.id == '0) begin
							emit = 1'b1;
							emit_res.status = ST_INVALID;
						end else if (!map_q[req_q.id]) begin
							emit = 1'b1;
							emit_res.status = ST_NONE;
						end else begin
							map_d = map_q & ~(TABLE_DEPTH'(1) << req_q.id);
							if (hint_q >= HINT_W'(req_q.id)) begin
								hint_d = HINT_W'(req_q.id);
							end
							cnt_d   = cnt_q - ID_W'(1);
							state_d = S_UHI;
						end
					end
					OP_GET: begin
						if (req_q.id != '0 && map_q[req_q.id]) begin
							pst_d   = ST_OK;
							pid_d   = req_q.id;
							state_d = S_READ;
						end else begin
							emit = 1'b1;
							emit_res.status = ST_NONE;
						end
					end
					OP_FIRST, OP_LAST, OP_NEXT, OP_PREV: begin
						if (req_q.opcode == OP_LAST || req_q.opcode == OP_PREV) begin
							scmd.from_top = 1'b1;
						end
						if (req_q.opcode == OP_NEXT) begin
							scmd.lo = HINT_W'(req_q.id) + HINT_W'(1);
						end
						if (req_q.opcode == OP_PREV) begin
							scmd.hi = req_q.id - ID_W'(1);
						end
						if (srsp.hit && !(req_q.opcode == OP_PREV && req_q.id == '0)) begin
							raddr   = srsp.idx;
							pst_d   = ST_OK;
							pid_d   = srsp.idx;
							state_d = S_READ;
						end else begin
							emit = 1'b1;
							emit_res.status = ST_NONE;
						end
					end
					OP_FIRST_FREE: begin
						pick = hint_q;
						if (!hint_q[HINT_W-1] && map_q[hint_q[ID_W-1:0]]) begin
							scmd.invert = 1'b1;
							scmd.lo     = hint_q;
							pick   = srsp.hit ? HINT_W'(srsp.idx) : HINT_W'(TABLE_DEPTH);
							hint_d = pick;
						end
						emit = 1'b1;
						if (pick[HINT_W-1]) begin
							emit_res.status = ST_FULL;
						end else begin
							emit_res.result_id = pick[ID_W-1:0];
						end
					end
					OP_COUNT: begin
						emit = 1'b1;
						emit_res.occupied_count = cnt_q;
					end
					OP_COMPACT: begin
						next_d  = HINT_W'(1);
						state_d = S_CSCAN;
					end
					OP_CLEAR: begin
						map_d  = '0;
						hint_d = HINT_W'(1);
						high_d = '0;
						cnt_d  = '0;
						emit   = 1'b1;
					end
					default: begin
						emit = 1'b1;
						emit_res.status = ST_INVALID;
					end
				endcase
			end
			S_READ: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				emit_res.status        = pst_q;
				emit_res.result_id     = pid_q;
				emit_res.result_handle = rdata_q;
			end
			S_UHI: begin
				// map already cleared; highest id is the top remaining entry
				scmd.from_top = 1'b1;
				high_d  = srsp.hit ? srsp.idx : '0;
				state_d = S_IDLE;
				emit    = 1'b1;
				emit_res.result_id     = req_q.id;
				emit_res.result_handle = rdata_q;
			end
			S_CSCAN: begin
				scmd.lo = next_q;
				if (!srsp.hit) begin
					hint_d  = next_q;
					high_d  = ID_W'(next_q - HINT_W'(1));
					state_d = S_IDLE;
					emit    = 1'b1;
					emit_res.result_id      = ID_W'(next_q - HINT_W'(1));
					emit_res.occupied_count = cnt_q;
				end else if (HINT_W'(srsp.idx) == next_q) begin
					next_d = next_q + HINT_W'(1);
				end else begin
					raddr   = srsp.idx;
					src_d   = srsp.idx;
					state_d = S_CMOVE;
				end
			end
			S_CMOVE: begin
				we    = 1'b1;
				waddr = next_q[ID_W-1:0];
				wdata = rdata_q;
				map_d = (map_q & ~(TABLE_DEPTH'(1) << src_q)) |
					(TABLE_DEPTH'(1) << next_q[ID_W-1:0]);
				next_d  = next_q + HINT_W'(1);
				state_d = S_CSCAN;
				emit    = 1'b1;
				emit_res.result_id      = next_q[ID_W-1:0];
				emit_res.result_handle  = rdata_q;
				emit_res.old_id         = src_q;
				emit_res.occupied_count = cnt_q;
				emit_res.last           = 1'b0;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			map_q    <= '0;
			hint_q   <= HINT_W'(1);
			high_q   <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			map_q    <= map_d;
			hint_q   <= hint_d;
			high_q   <= high_d;
			cnt_q    <= cnt_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= request;
		end
		next_q <= next_d;
		src_q  <= src_d;
		pst_q  <= pst_d;
		pid_q  <= pid_d;
		if (emit) begin
			res_q <= emit_res;
		end
	end

	// handle memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule
`default_nettype wire

// File: bench/serial_id_registry_tb.sv
// Self-checking testbench for serial_id_registry: directed table, random requests, predictor.
`default_nettype none
module serial_id_registry_tb import sir_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] OP_UNDEFINED = 4'hF;
	localparam int         N_DIRECTED   = 25;
	localparam int         N_TOTAL      = 325;

	typedef struct packed {
		logic [3:0]          op;
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] hnd;
		logic                typed;
		status_t             st;
		logic [ID_W-1:0]     rid;
		logic [HANDLE_W-1:0] rhnd;
		logic [ID_W-1:0]     cnt;
	} step_row_t;

	logic     clk;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     result_strobe;
	result_t  result;

	// predicted registry state
	logic [TABLE_DEPTH-1:0] occ_map;
	logic [HANDLE_W-1:0]    handle_mem [TABLE_DEPTH];
	int                     free_hint;
	int                     top_id;

	result_t   expected_results [$];
	step_row_t dir_rows [N_DIRECTED];
	result_t   want;
	int        errors;
	int        requests_sent;
	int        results_checked;
	int        entries_moved;
	int        fills;
	int        calm;

	serial_id_registry i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.busy         (busy),
		.result_strobe(result_strobe),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic taken(input int n);
		return (n > 0 && n < TABLE_DEPTH) ? occ_map[n] : 1'b0;
	endfunction

	function automatic result_t found_at(input int n);
		result_t res;
		res = '0;
		res.last = 1'b1;
		if (n != 0 && taken(n)) begin
			res.status        = ST_OK;
			res.result_id     = ID_W'(n);
			res.result_handle = handle_mem[n];
		end else begin
			res.status = ST_NONE;
		end
		return res;
	endfunction

	task automatic predict_registry(input request_t r);
		int      n;
		int      nxt;
		int      cnt;
		result_t res;
		res = '0;
		res.last = 1'b1;
		res.status = ST_OK;
		case (r.opcode)
			OP_ASSIGN: begin
				n = (r.id == '0) ? top_id + 1 : int'(r.id);
				if (n >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else if (taken(n)) begin
					res.status        = ST_OCCUPIED;
					res.result_id     = ID_W'(n);
					res.result_handle = handle_mem[n];
				end else begin
					occ_map[n]    = 1'b1;
					handle_mem[n] = r.handle;
					if (n > top_id) top_id = n;
					res.result_id     = ID_W'(n);
					res.result_handle = r.handle;
				end
			end
			OP_UNASSIGN: begin
				n = int'(r.id);
				if (n == 0) begin
					res.status = ST_INVALID;
				end else if (!taken(n)) begin
					res.status = ST_NONE;
				end else begin
					occ_map[n] = 1'b0;
					if (free_hint >= n) free_hint = n;
					while (top_id > 0 && !taken(top_id)) top_id--;
					res.result_id     = ID_W'(n);
					res.result_handle = handle_mem[n];
				end
			end
			OP_GET: res = found_at(int'(r.id));
			OP_FIRST: begin
				n = 1;
				while (n < TABLE_DEPTH && !taken(n)) n++;
				res = found_at(n);
			end
			OP_LAST: begin
				n = top_id;
				while (n > 0 && !taken(n)) n--;
				res = found_at(n);
			end
			OP_NEXT: begin
				n = int'(r.id) + 1;
				while (n < TABLE_DEPTH && !taken(n)) n++;
				res = found_at(n);
			end
			OP_PREV: begin
				n = (r.id == '0) ? 0 : int'(r.id) - 1;
				while (n > 0 && !taken(n)) n--;
				res = found_at(n);
			end
			OP_FIRST_FREE: begin
				n = free_hint;
				if (n < TABLE_DEPTH && taken(n)) begin
					while (n < TABLE_DEPTH && taken(n)) n++;
					free_hint = n;
				end
				if (n >= TABLE_DEPTH) res.status = ST_FULL;
				else res.result_id = ID_W'(n);
			end
			OP_COUNT: res.occupied_count = ID_W'($countones(occ_map));
			OP_COMPACT: begin
				cnt = $countones(occ_map);
				nxt = 1;
				for (n = 1; n < TABLE_DEPTH; n++) begin
					if (taken(n)) begin
						if (nxt < n) begin
							handle_mem[nxt] = handle_mem[n];
							occ_map[n]      = 1'b0;
							occ_map[nxt]    = 1'b1;
							res.result_id      = ID_W'(nxt);
							res.result_handle  = handle_mem[nxt];
							res.old_id         = ID_W'(n);
							res.occupied_count = ID_W'(cnt);
							res.last           = 1'b0;
							expected_results.push_back(res);
							entries_moved++;
						end
						nxt++;
					end
				end
				free_hint = nxt;
				top_id    = nxt - 1;
				res = '0;
				res.status         = ST_OK;
				res.result_id      = ID_W'(top_id);
				res.occupied_count = ID_W'(cnt);
				res.last           = 1'b1;
			end
			OP_CLEAR: begin
				occ_map   = '0;
				free_hint = 1;
				top_id    = 0;
			end
			default: res.status = ST_INVALID;
		endcase
		expected_results.push_back(res);
	endtask

	task automatic send_request(input request_t r, input logic typed, input result_t typed_res);
		int gap;
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 30);
			gap = $urandom_range(0, 99);
			if (gap < 50) gap = 0;
			else if (gap < 90) gap = $urandom_range(1, 3);
			else gap = $urandom_range(4, 30);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		predict_registry(r);
		if (typed) begin
			void'(expected_results.pop_back());
			expected_results.push_back(typed_res);
		end
		requests_sent++;
	endtask

	function automatic request_t mk(input logic [3:0] op, input int id,
		input logic [HANDLE_W-1:0] h);
		request_t r;
		r.opcode = op;
		r.id     = ID_W'(id);
		r.handle = h;
		return r;
	endfunction

	function automatic int taken_id();
		int n;
		n = $urandom_range(1, TABLE_DEPTH - 1);
		if (occ_map != '0)
			while (!taken(n)) n = $urandom_range(1, TABLE_DEPTH - 1);
		return n;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		r.handle = $urandom();
		r.id     = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom());
		pick     = $urandom_range(0, 99);
		if (pick < 30) begin
			r.opcode = OP_ASSIGN;
			if ($urandom_range(0, 2) == 0) r.id = '0;
		end else if (pick < 45) begin
			r.opcode = OP_UNASSIGN;
			if ($urandom_range(0, 2) != 0) r.id = ID_W'(taken_id());
		end else if (pick < 70) begin
			r.opcode = 4'($urandom_range(OP_GET, OP_PREV));
			if (r.opcode == OP_GET && $urandom_range(0, 1)) r.id = ID_W'(taken_id());
		end else if (pick < 79) begin
			r.opcode = OP_FIRST_FREE;
		end else if (pick < 86) begin
			r.opcode = OP_COUNT;
		end else if (pick < 94) begin
			r.opcode = OP_COMPACT;
		end else if (pick < 96) begin
			r.opcode = OP_CLEAR;
		end else begin
			r.opcode = 4'($urandom_range(OP_CLEAR + 1, OP_UNDEFINED));
		end
		return r;
	endfunction

	// pack the table densely, top it up to capacity, then punch holes and repack
	task automatic fill_table();
		send_request(mk(OP_COMPACT, 0, $urandom()), 1'b0, '0);
		while (top_id < TABLE_DEPTH - 1)
			send_request(mk(OP_ASSIGN, 0, $urandom()), 1'b0, '0);
		send_request(mk(OP_ASSIGN, 0, $urandom()), 1'b0, '0);
		send_request(mk(OP_FIRST_FREE, 0, $urandom()), 1'b0, '0);
		send_request(mk(OP_COUNT, 0, $urandom()), 1'b0, '0);
		send_request(mk(OP_COMPACT, 0, $urandom()), 1'b0, '0);
		repeat ($urandom_range(3, 12))
			send_request(mk(OP_UNASSIGN, taken_id(), $urandom()), 1'b0, '0);
		send_request(mk(OP_FIRST_FREE, 0, $urandom()), 1'b0, '0);
		send_request(mk(OP_COMPACT, 0, $urandom()), 1'b0, '0);
		fills++;
	endtask

	task automatic report_field(input string fname, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, got_v);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_field("status", want.status, result.status);
				if (result.result_id !== want.result_id)
					report_field("result_id", want.result_id, result.result_id);
				if (result.result_handle !== want.result_handle)
					report_field("result_handle", want.result_handle, result.result_handle);
				if (result.old_id !== want.old_id)
					report_field("old_id", want.old_id, result.old_id);
				if (result.occupied_count !== want.occupied_count)
					report_field("occupied_count", want.occupied_count, result.occupied_count);
				if (result.last !== want.last)
					report_field("last", want.last, result.last);
			end
		end
	end

	initial begin
		result_t typed_res;
		int      i;
		errors = 0;
		requests_sent = 0;
		results_checked = 0;
		entries_moved = 0;
		fills = 0;
		calm = 0;
		occ_map = '0;
		free_hint = 1;
		top_id = 0;
		dir_rows = '{
			'{OP_GET,        6'd5,  32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0},
			'{OP_FIRST,      6'd0,  32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0},
			'{OP_LAST,       6'd0,  32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0},
			'{OP_COUNT,      6'd0,  32'h0,        1'b1, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_FIRST_FREE, 6'd0,  32'h0,        1'b1, ST_OK,       6'd1,  32'h0,        6'd0},
			'{OP_UNASSIGN,   6'd0,  32'h0,        1'b1, ST_INVALID,  6'd0,  32'h0,        6'd0},
			'{OP_UNASSIGN,   6'd7,  32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0},
			'{OP_PREV,       6'd0,  32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0},
			'{OP_ASSIGN,     6'd0,  32'hFFFFFFFF, 1'b1, ST_OK,       6'd1,  32'hFFFFFFFF, 6'd0},
			'{OP_ASSIGN,     6'd63, 32'h0,        1'b1, ST_OK,       6'd63, 32'h0,        6'd0},
			'{OP_ASSIGN,     6'd0,  32'hA5A5A5A5, 1'b1, ST_FULL,     6'd0,  32'h0,        6'd0},
			'{OP_ASSIGN,     6'd63, 32'h1,        1'b1, ST_OCCUPIED, 6'd63, 32'h0,        6'd0},
			'{OP_ASSIGN,     6'd32, 32'h5A5A5A5A, 1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_NEXT,       6'd63, 32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0},
			'{OP_NEXT,       6'd1,  32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_PREV,       6'd63, 32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_LAST,       6'd0,  32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_GET,        6'd63, 32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_FIRST_FREE, 6'd0,  32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_UNASSIGN,   6'd32, 32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_COMPACT,    6'd0,  32'h0,        1'b0, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_UNDEFINED,  6'd0,  32'h0,        1'b1, ST_INVALID,  6'd0,  32'h0,        6'd0},
			'{OP_CLEAR,      6'd0,  32'h0,        1'b1, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_COUNT,      6'd0,  32'h0,        1'b1, ST_OK,       6'd0,  32'h0,        6'd0},
			'{OP_GET,        6'd1,  32'h0,        1'b1, ST_NONE,     6'd0,  32'h0,        6'd0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < N_DIRECTED; i++) begin
			typed_res = '0;
			typed_res.status         = dir_rows[i].st;
			typed_res.result_id      = dir_rows[i].rid;
			typed_res.result_handle  = dir_rows[i].rhnd;
			typed_res.occupied_count = dir_rows[i].cnt;
			typed_res.last           = 1'b1;
			send_request(mk(dir_rows[i].op, int'(dir_rows[i].id), dir_rows[i].hnd),
				dir_rows[i].typed, typed_res);
		end
		while (requests_sent < N_TOTAL) begin
			if ((requests_sent >= 110 && fills == 0) || (requests_sent >= 220 && fills == 1))
				fill_table();
			else
				send_request(random_request(), 1'b0, '0);
		end
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Issued %0d requests (%0d from the directed table), checked %0d results.",
			requests_sent, N_DIRECTED, results_checked);
		$display("Table filled to capacity %0d times; compaction moved %0d entries.",
			fills, entries_moved);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
